// File: hdl/hfl_pkg.sv
// shared types and constants of the handle free list allocator
package hfl_pkg;

  localparam int HANDLE_W        = 12;
  localparam int DATA_W          = 64;
  localparam int FUNC_W          = 2;
  localparam int STATUS_W        = 3;
  localparam int SLOTS_DEF       = 4096;
  localparam int VALUE_WIDTH_DEF = 64;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_GET   = 2'd2,
    FN_SET   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NONE_FREE = 3'd1,
    ST_RANGE     = 3'd2,
    ST_NOT_USED  = 3'd3,
    ST_DOUBLE    = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } sts_t;

endpackage

// File: hdl/hfl_ctrl.sv
// controller state machine: clearing pass, request accept, execute
module hfl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  hfl_pkg::sts_t sts,
  output hfl_pkg::cmd_t cmd
);

  hfl_pkg::state_t state_r;
  hfl_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hfl_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hfl_pkg::S_CLEAR: begin
        if (sts.clear_last) state_nxt = hfl_pkg::S_IDLE;
      end
      hfl_pkg::S_IDLE: begin
        if (in_valid) state_nxt = hfl_pkg::S_EXEC;
      end
      hfl_pkg::S_EXEC: begin
        if (sts.out_free) state_nxt = hfl_pkg::S_IDLE;
      end
      default: state_nxt = hfl_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      hfl_pkg::S_CLEAR: begin
        cmd.clear = 1'b1;
      end
      hfl_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      hfl_pkg::S_EXEC: begin
        cmd.exec = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// File: hdl/hfl_datapath.sv
// datapath: free stack, in-use bits, slot values, free count and result register
module hfl_datapath #(
  parameter int SLOTS       = hfl_pkg::SLOTS_DEF,
  parameter int VALUE_WIDTH = hfl_pkg::VALUE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hfl_pkg::cmd_t                cmd,
  output hfl_pkg::sts_t                sts,
  input  logic [hfl_pkg::FUNC_W-1:0]   in_func,
  input  logic [hfl_pkg::HANDLE_W-1:0] in_handle,
  input  logic [hfl_pkg::DATA_W-1:0]   in_value,
  input  logic                         cfg_wr,
  input  logic [hfl_pkg::DATA_W-1:0]   cfg_null_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hfl_pkg::HANDLE_W-1:0] out_handle_out,
  output logic [hfl_pkg::DATA_W-1:0]   out_read_value,
  output logic                         out_handle_ok,
  output logic [hfl_pkg::STATUS_W-1:0] out_status
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  // memories
  logic [AW-1:0]          stk_mem [SLOTS];
  logic                   use_mem [SLOTS];
  logic [VALUE_WIDTH-1:0] val_mem [SLOTS];

  // request registers
  hfl_pkg::func_t         func_r;
  logic [AW-1:0]          hidx_r;
  logic                   in_range_r;
  logic [VALUE_WIDTH-1:0] value_r;
  logic [AW-1:0]          pop_idx_r;
  logic                   pop_init_r;

  // memory read data
  logic [AW-1:0]          stk_q;
  logic                   use_q;
  logic [VALUE_WIDTH-1:0] val_q;

  // control state
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] low_r, low_nxt;
  logic [AW-1:0] clr_addr_r;
  logic [hfl_pkg::DATA_W-1:0] null_r;
  logic          out_valid_r, out_valid_nxt;

  // result register
  logic [hfl_pkg::HANDLE_W-1:0] hout_r, hout_nxt;
  logic [hfl_pkg::DATA_W-1:0]   rval_r, rval_nxt;
  logic                         ok_r, ok_nxt;
  hfl_pkg::status_t             status_r, status_nxt;

  // accept side
  logic          in_range;
  logic [AW-1:0] hidx;
  logic [CW-1:0] pop_cnt;
  logic [AW-1:0] pop_idx;

  // execute side
  logic [AW-1:0] popped;
  logic          valid;
  logic          use_we, use_wd;
  logic [AW-1:0] use_wa;
  logic          stk_we;
  logic          val_we;

  assign in_range = 32'(in_handle) < 32'(SLOTS);
  assign hidx     = AW'(in_handle);
  assign pop_cnt  = count_r - CW'(1);
  assign pop_idx  = AW'(pop_cnt);

  // entries below the lowest count ever reached were never overwritten
  assign popped = pop_init_r ? pop_idx_r : stk_q;
  assign valid  = in_range_r && use_q;

  assign sts.clear_last = clr_addr_r == AW'(SLOTS - 1);
  assign sts.out_free   = !out_valid_r || out_ready;

  // popped handles are never in use, so alloc needs no in-use lookup
  always_comb begin
    count_nxt  = count_r;
    low_nxt    = low_r;
    hout_nxt   = '0;
    rval_nxt   = '0;
    ok_nxt     = 1'b0;
    status_nxt = hfl_pkg::ST_OK;
    use_we     = 1'b0;
    use_wd     = 1'b0;
    use_wa     = hidx_r;
    stk_we     = 1'b0;
    val_we     = 1'b0;
    unique case (func_r)
      hfl_pkg::FN_ALLOC: begin
        if (count_r == '0) begin
          status_nxt = hfl_pkg::ST_NONE_FREE;
        end else begin
          count_nxt = pop_cnt;
          if (pop_cnt < low_r) low_nxt = pop_cnt;
          use_we   = 1'b1;
          use_wd   = 1'b1;
          use_wa   = popped;
          hout_nxt = hfl_pkg::HANDLE_W'(popped);
        end
      end
      hfl_pkg::FN_FREE: begin
        if (count_r == CW'(SLOTS)) begin
          status_nxt = hfl_pkg::ST_FULL;
        end else if (!in_range_r) begin
          status_nxt = hfl_pkg::ST_RANGE;
        end else if (!use_q) begin
          status_nxt = hfl_pkg::ST_NOT_USED;
        end else begin
          use_we    = 1'b1;
          stk_we    = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      hfl_pkg::FN_GET: begin
        if (valid) begin
          rval_nxt = hfl_pkg::DATA_W'(val_q);
          ok_nxt   = 1'b1;
        end else begin
          rval_nxt   = null_r;
          status_nxt = in_range_r ? hfl_pkg::ST_NOT_USED : hfl_pkg::ST_RANGE;
        end
      end
      hfl_pkg::FN_SET: begin
        if (valid) begin
          val_we = 1'b1;
          ok_nxt = 1'b1;
        end else begin
          status_nxt = in_range_r ? hfl_pkg::ST_NOT_USED : hfl_pkg::ST_RANGE;
        end
      end
      default: status_nxt = hfl_pkg::ST_OK;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= CW'(SLOTS);
      low_r       <= CW'(SLOTS);
      clr_addr_r  <= '0;
      null_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.clear) clr_addr_r <= clr_addr_r + AW'(1);
      if (cfg_wr) null_r <= cfg_null_value;
      if (cmd.exec) begin
        count_r <= count_nxt;
        low_r   <= low_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r     <= hfl_pkg::func_t'(in_func);
      hidx_r     <= hidx;
      in_range_r <= in_range;
      value_r    <= VALUE_WIDTH'(in_value);
      pop_idx_r  <= pop_idx;
      pop_init_r <= pop_cnt < low_r;
    end
    if (cmd.exec) begin
      hout_r   <= hout_nxt;
      rval_r   <= rval_nxt;
      ok_r     <= ok_nxt;
      status_r <= status_nxt;
    end
  end

  // free stack
  always_ff @(posedge clk) begin
    if (cmd.accept) stk_q <= stk_mem[pop_idx];
    if (cmd.exec && stk_we) stk_mem[AW'(count_r)] <= hidx_r;
  end

  // in-use bits, swept to zero after reset
  always_ff @(posedge clk) begin
    if (cmd.accept) use_q <= use_mem[hidx];
    if (cmd.clear) begin
      use_mem[clr_addr_r] <= 1'b0;
    end else if (cmd.exec && use_we) begin
      use_mem[use_wa] <= use_wd;
    end
  end

  // slot values
  always_ff @(posedge clk) begin
    if (cmd.accept) val_q <= val_mem[hidx];
    if (cmd.exec && val_we) val_mem[hidx_r] <= value_r;
  end

  assign out_valid      = out_valid_r;
  assign out_handle_out = hout_r;
  assign out_read_value = rval_r;
  assign out_handle_ok  = ok_r;
  assign out_status     = status_r;

endmodule

// File: hdl/handle_free_list_allocator.sv
// top level of the handle free list allocator
//
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_ready    in_func, in_handle, in_value
//  out_     output     out_valid / out_ready  out_handle_out, out_read_value,
//                                             out_handle_ok, out_status
//  cfg_     input      cfg_valid / cfg_ready  cfg_null_value
//
// each request has an accept cycle with the memory reads, then an execute
// cycle with compute and memory writes; the split follows the read-then-write
// of the free stack, in-use and value memories
// after reset an in-use clearing pass runs over all SLOTS entries with in_ready low
// the execute cycle holds while a result waits and out_ready is low
module handle_free_list_allocator #(
  parameter int SLOTS       = hfl_pkg::SLOTS_DEF,
  parameter int VALUE_WIDTH = hfl_pkg::VALUE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [hfl_pkg::FUNC_W-1:0]   in_func,
  input  logic [hfl_pkg::HANDLE_W-1:0] in_handle,
  input  logic [hfl_pkg::DATA_W-1:0]   in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hfl_pkg::HANDLE_W-1:0] out_handle_out,
  output logic [hfl_pkg::DATA_W-1:0]   out_read_value,
  output logic                         out_handle_ok,
  output logic [hfl_pkg::STATUS_W-1:0] out_status,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [hfl_pkg::DATA_W-1:0]   cfg_null_value
);

  hfl_pkg::cmd_t cmd;
  hfl_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  hfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hfl_datapath #(
    .SLOTS       (SLOTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_func        (in_func),
    .in_handle      (in_handle),
    .in_value       (in_value),
    .cfg_wr         (cfg_valid && cfg_ready),
    .cfg_null_value (cfg_null_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_handle_out (out_handle_out),
    .out_read_value (out_read_value),
    .out_handle_ok  (out_handle_ok),
    .out_status     (out_status)
  );

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  // a valid handle always means success
  a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_handle_ok |-> out_status == hfl_pkg::ST_OK)
    else $error("handle_ok with error status");

  // failures grant nothing
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != hfl_pkg::ST_OK
      |-> out_handle_out == '0 && !out_handle_ok)
    else $error("failed request carries a handle or ok flag");

  // the free stack never hands out a handle in use
  a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != hfl_pkg::ST_DOUBLE)
    else $error("double alloc reported");

endmodule

// File: verif/hfl_reply_checker.sv
`timescale 1ns / 1ps
// reply checker: tracks the handle table, predicts each reply and compares it
module hfl_reply_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [hfl_pkg::FUNC_W-1:0]   in_func,
  input  logic [hfl_pkg::HANDLE_W-1:0] in_handle,
  input  logic [hfl_pkg::DATA_W-1:0]   in_value,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [hfl_pkg::HANDLE_W-1:0] out_handle_out,
  input  logic [hfl_pkg::DATA_W-1:0]   out_read_value,
  input  logic                         out_handle_ok,
  input  logic [hfl_pkg::STATUS_W-1:0] out_status,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [hfl_pkg::DATA_W-1:0]   cfg_null_value,
  output int                           fail_count
);

  localparam int SLOTS       = hfl_pkg::SLOTS_DEF;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [hfl_pkg::HANDLE_W-1:0] handle_out;
    logic [hfl_pkg::DATA_W-1:0]   read_value;
    logic                         handle_ok;
    hfl_pkg::status_t             status;
  } reply_t;

  logic [hfl_pkg::HANDLE_W-1:0] free_stack [SLOTS];
  int unsigned                  free_count;
  bit                           in_use [SLOTS];
  logic [hfl_pkg::DATA_W-1:0]   slot_value [SLOTS];
  logic [hfl_pkg::DATA_W-1:0]   null_value;
  reply_t                       replies_due [$];
  int                           mismatches = 0;

  assign fail_count = mismatches;

  function automatic reply_t table_op(hfl_pkg::func_t op,
                                      logic [hfl_pkg::HANDLE_W-1:0] h,
                                      logic [hfl_pkg::DATA_W-1:0] v);
    reply_t                       r;
    logic [hfl_pkg::HANDLE_W-1:0] g;
    bit                           in_range;
    bit                           valid;
    r.handle_out = '0;
    r.read_value = '0;
    r.handle_ok  = 1'b0;
    r.status     = hfl_pkg::ST_OK;
    in_range = int'(h) < SLOTS;
    valid    = in_range && in_use[h];
    case (op)
      hfl_pkg::FN_ALLOC: begin
        if (free_count == 0) begin
          r.status = hfl_pkg::ST_NONE_FREE;
        end else begin
          free_count--;
          g = free_stack[free_count];
          if (in_use[g]) begin
            r.status = hfl_pkg::ST_DOUBLE;
          end else begin
            in_use[g]    = 1'b1;
            r.handle_out = g;
          end
        end
      end
      hfl_pkg::FN_FREE: begin
        if (free_count >= SLOTS) begin
          r.status = hfl_pkg::ST_FULL;
        end else if (!in_range) begin
          r.status = hfl_pkg::ST_RANGE;
        end else if (!in_use[h]) begin
          r.status = hfl_pkg::ST_NOT_USED;
        end else begin
          in_use[h]              = 1'b0;
          free_stack[free_count] = h;
          free_count++;
        end
      end
      hfl_pkg::FN_GET: begin
        if (valid) begin
          r.read_value = slot_value[h];
          r.handle_ok  = 1'b1;
        end else begin
          r.read_value = null_value;
          r.status     = in_range ? hfl_pkg::ST_NOT_USED : hfl_pkg::ST_RANGE;
        end
      end
      default: begin
        if (valid) begin
          slot_value[h] = v;
          r.handle_ok   = 1'b1;
        end else begin
          r.status = in_range ? hfl_pkg::ST_NOT_USED : hfl_pkg::ST_RANGE;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        free_stack[i] = hfl_pkg::HANDLE_W'(i);
        in_use[i]     = 1'b0;
        slot_value[i] = '0;
      end
      free_count = SLOTS;
      null_value = '0;
      replies_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        null_value = cfg_null_value;
      end
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("unexpected reply: handle %0d value %h ok %0d status %0d",
                     out_handle_out, out_read_value, out_handle_ok, out_status);
          end
        end else begin
          want = replies_due.pop_front();
          if (out_handle_out !== want.handle_out || out_read_value !== want.read_value ||
              out_handle_ok !== want.handle_ok || out_status !== want.status) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("reply mismatch at %0t: expected handle %0d value %h ok %0d status %0d",
                       $realtime, want.handle_out, want.read_value, want.handle_ok,
                       want.status);
              $display("  got handle %0d value %h ok %0d status %0d",
                       out_handle_out, out_read_value, out_handle_ok, out_status);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        replies_due.push_back(table_op(hfl_pkg::func_t'(in_func), in_handle, in_value));
      end
    end
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// top of the allocator testbench: clock, reset, request stimulus and verdict
module testbench;

  localparam int SLOTS       = hfl_pkg::SLOTS_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam int PHASE_ITEMS = 300;
  localparam int TAIL_ITEMS  = 300;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [hfl_pkg::FUNC_W-1:0]   in_func = '0;
  logic [hfl_pkg::HANDLE_W-1:0] in_handle = '0;
  logic [hfl_pkg::DATA_W-1:0]   in_value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [hfl_pkg::HANDLE_W-1:0] out_handle_out;
  logic [hfl_pkg::DATA_W-1:0]   out_read_value;
  logic                         out_handle_ok;
  logic [hfl_pkg::STATUS_W-1:0] out_status;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [hfl_pkg::DATA_W-1:0]   cfg_null_value = '0;

  int                           failures;
  int                           in_gap_pct = 0;
  int                           out_stall_pct = 0;
  int                           quiet_cycles = 0;
  int                           allocs_in_flight = 0;
  bit                           live [SLOTS];
  bit                           written [SLOTS];
  logic [hfl_pkg::HANDLE_W-1:0] live_q [$];
  logic [hfl_pkg::HANDLE_W-1:0] written_q [$];
  hfl_pkg::func_t               sent_ops [$];

  handle_free_list_allocator dut (.*);

  hfl_reply_checker replies (.*, .fail_count(failures));

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // learn granted handles from alloc replies, count quiet cycles
  always @(posedge clk) begin : track
    hfl_pkg::func_t op;
    if (rst_n) begin
      if (out_valid && out_ready && sent_ops.size() != 0) begin
        op = sent_ops.pop_front();
        if (op == hfl_pkg::FN_ALLOC) begin
          allocs_in_flight--;
          if (out_status == hfl_pkg::ST_OK && !live[out_handle_out]) begin
            live[out_handle_out] = 1'b1;
            live_q.push_back(out_handle_out);
          end
        end
      end
      if (in_valid && in_ready) begin
        sent_ops.push_back(hfl_pkg::func_t'(in_func));
        if (hfl_pkg::func_t'(in_func) == hfl_pkg::FN_ALLOC) allocs_in_flight++;
      end
    end
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  function automatic void forget(logic [hfl_pkg::HANDLE_W-1:0] h);
    int i;
    live[h] = 1'b0;
    for (i = live_q.size() - 1; i >= 0; i--) begin
      if (live_q[i] == h) begin
        live_q[i] = live_q[live_q.size() - 1];
        void'(live_q.pop_back());
        break;
      end
    end
  endfunction

  task automatic send(hfl_pkg::func_t op, logic [hfl_pkg::HANDLE_W-1:0] h,
                      logic [hfl_pkg::DATA_W-1:0] v);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    if (op == hfl_pkg::FN_SET && live[h] && !written[h]) begin
      written[h] = 1'b1;
      written_q.push_back(h);
    end
    if (op == hfl_pkg::FN_FREE && live[h]) forget(h);
    in_valid  <= 1'b1;
    in_func   <= op;
    in_handle <= h;
    in_value  <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sent_ops.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_null(logic [hfl_pkg::DATA_W-1:0] v);
    cfg_valid      <= 1'b1;
    cfg_null_value <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed use of granted handles, some random noise
  task automatic random_request();
    int                           pick;
    hfl_pkg::func_t               op;
    logic [hfl_pkg::HANDLE_W-1:0] h;
    logic [hfl_pkg::DATA_W-1:0]   v;
    v    = {$urandom, $urandom};
    h    = hfl_pkg::HANDLE_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 25) begin
      op = hfl_pkg::FN_ALLOC;
    end else if (pick < 45 && live_q.size() != 0) begin
      op = hfl_pkg::FN_FREE;
      h  = live_q[$urandom_range(live_q.size() - 1)];
    end else if (pick < 65 && live_q.size() != 0) begin
      op = hfl_pkg::FN_SET;
      h  = live_q[$urandom_range(live_q.size() - 1)];
    end else if (pick < 80 && written_q.size() != 0) begin
      op = hfl_pkg::FN_GET;
      h  = written_q[$urandom_range(written_q.size() - 1)];
    end else begin
      op = hfl_pkg::func_t'($urandom_range(3));
      // keep the handle bookkeeping exact and never read an unwritten slot
      if (op == hfl_pkg::FN_FREE && (allocs_in_flight != 0 || live[h])) begin
        op = hfl_pkg::FN_SET;
      end
      if (op == hfl_pkg::FN_GET && !written[h] && (live[h] || allocs_in_flight != 0)) begin
        op = hfl_pkg::FN_SET;
      end
    end
    send(op, h, v);
  endtask

  initial begin : stimulus
    logic [hfl_pkg::HANDLE_W-1:0] h_a, h_b, h_c;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    in_gap_pct    = 12;
    out_stall_pct = 76;
    write_null('1);
    send(hfl_pkg::FN_FREE, '0, '0);
    send(hfl_pkg::FN_FREE, '1, '1);
    send(hfl_pkg::FN_GET, '0, '0);
    send(hfl_pkg::FN_GET, '1, '0);
    send(hfl_pkg::FN_SET, '1, '1);
    repeat (3) send(hfl_pkg::FN_ALLOC, '1, '1);
    drain();
    h_a = live_q[0];
    h_b = live_q[1];
    h_c = live_q[2];
    send(hfl_pkg::FN_SET, h_a, '1);
    send(hfl_pkg::FN_SET, h_b, '0);
    send(hfl_pkg::FN_SET, h_c, 64'h5555_5555_5555_5555);
    send(hfl_pkg::FN_GET, h_a, '0);
    send(hfl_pkg::FN_GET, h_b, '0);
    send(hfl_pkg::FN_GET, h_c, '1);
    send(hfl_pkg::FN_FREE, h_b, '0);
    send(hfl_pkg::FN_FREE, h_b, '0);
    send(hfl_pkg::FN_GET, h_b, '0);
    send(hfl_pkg::FN_SET, h_b, '1);
    send(hfl_pkg::FN_ALLOC, '0, '0);
    drain();
    send(hfl_pkg::FN_GET, h_b, '0);
    repeat (PHASE_ITEMS) random_request();
    drain();

    write_null('0);
    in_gap_pct    = 76;
    out_stall_pct = 12;
    repeat (PHASE_ITEMS) random_request();
    drain();

    write_null({$urandom, $urandom});
    in_gap_pct    = 0;
    out_stall_pct = 0;
    repeat (TAIL_ITEMS) random_request();
    drain();

    write_null(64'h8000_0000_0000_0001);
    while (live_q.size() != 0) send(hfl_pkg::FN_FREE, live_q[live_q.size() - 1], '0);
    send(hfl_pkg::FN_FREE, hfl_pkg::HANDLE_W'($urandom), '0);
    send(hfl_pkg::FN_FREE, '1, '0);
    send(hfl_pkg::FN_GET, hfl_pkg::HANDLE_W'($urandom), '0);
    drain();
    repeat (8) @(negedge clk);

    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
